FILE: sv/mqsb_pkg.sv
package mqsb_pkg;

   localparam int DEF_ENTRIES = 16;
   localparam int DEF_QUEUES  = 4;
   localparam int WORD_W      = 32;
   localparam int QID_W       = 2;

   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    opcode;
      logic [QID_W-1:0]          queue_id;
      logic signed [WORD_W-1:0]  data_in;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [WORD_W-1:0]  data_out;
   } rsp_type;

   // Outcome of one executed operation, handed from the engine to the result register.
   typedef struct packed {
      status_type status;
      logic       from_mem;
   } exec_type;

endpackage

FILE: sv/mqsb_ram.sv
module mqsb_ram
   import mqsb_pkg::*;
#(
   parameter int DEPTH = DEF_ENTRIES,
   parameter int WIDTH = WORD_W
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;
   logic             byp_ff;
   logic [WIDTH-1:0] byp_data_ff;

   // A read that meets a write to the same address returns the new word.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff       <= mem[raddr];
         byp_ff      <= we && (waddr == raddr);
         byp_data_ff <= wdata;
      end
   end

   assign rdata = byp_ff ? byp_data_ff : rd_ff;

endmodule

FILE: sv/mqsb_engine.sv
module mqsb_engine
   import mqsb_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int QUEUES  = DEF_QUEUES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  op_type                     cur_op,
   input  logic [QID_W-1:0]           cur_qid,
   input  logic [WORD_W-1:0]          cur_data,
   input  op_type                     nxt_op,
   input  logic [QID_W-1:0]           nxt_qid,
   input  logic [$clog2(ENTRIES)-1:0] link_rdata,
   output logic [$clog2(ENTRIES)-1:0] link_raddr,
   output logic                       link_we,
   output logic [$clog2(ENTRIES)-1:0] link_waddr,
   output logic [$clog2(ENTRIES)-1:0] link_wdata,
   output logic                       data_we,
   output logic [$clog2(ENTRIES)-1:0] data_waddr,
   output logic [WORD_W-1:0]          data_wdata,
   output logic                       data_re,
   output logic [$clog2(ENTRIES)-1:0] data_raddr,
   output exec_type                   result
);

   localparam int PW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   logic [PW-1:0]     head_ff [QUEUES];
   logic [PW-1:0]     head_in [QUEUES];
   logic [PW-1:0]     tail_ff [QUEUES];
   logic [PW-1:0]     tail_in [QUEUES];
   logic [QUEUES-1:0] hval_ff, hval_in;
   logic [PW-1:0]     rec_head_ff, rec_head_in;
   logic [CW-1:0]     rec_cnt_ff, rec_cnt_in;
   logic [CW-1:0]     fresh_ff, fresh_in;

   logic [QW-1:0] qi;
   logic          qid_ok;
   logic          have_rec;
   logic          store_full;
   logic [PW-1:0] enq_idx;
   logic [PW-1:0] deq_idx;

   assign qi         = QW'(cur_qid);
   assign qid_ok     = 32'(cur_qid) < 32'(QUEUES);
   assign have_rec   = rec_cnt_ff != '0;
   assign store_full = !have_rec && (fresh_ff == CW'(ENTRIES));
   assign enq_idx    = have_rec ? rec_head_ff : fresh_ff[PW-1:0];
   assign deq_idx    = head_ff[qi];

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      hval_in       = hval_ff;
      rec_head_in   = rec_head_ff;
      rec_cnt_in    = rec_cnt_ff;
      fresh_in      = fresh_ff;
      link_we       = 1'b0;
      link_waddr    = enq_idx;
      link_wdata    = enq_idx;
      data_we       = 1'b0;
      data_waddr    = enq_idx;
      data_wdata    = cur_data;
      data_re       = 1'b0;
      data_raddr    = deq_idx;
      result.status   = ST_OK;
      result.from_mem = 1'b0;

      if (cur_op == OP_ENQ) begin
         if (!qid_ok || store_full) begin
            result.status = ST_FULL;
         end else if (fire) begin
            // Recycled entries are taken first, then untouched ones in order.
            if (have_rec) begin
               rec_head_in = link_rdata;
               rec_cnt_in  = rec_cnt_ff - CW'(1);
            end else begin
               fresh_in = fresh_ff + CW'(1);
            end
            if (hval_ff[qi]) begin
               link_we    = 1'b1;
               link_waddr = tail_ff[qi];
               link_wdata = enq_idx;
            end else begin
               head_in[qi] = enq_idx;
               hval_in[qi] = 1'b1;
            end
            tail_in[qi] = enq_idx;
            data_we     = 1'b1;
         end
      end else begin
         if (!qid_ok || !hval_ff[qi]) begin
            result.status = ST_EMPTY;
         end else begin
            result.from_mem = 1'b1;
            if (fire) begin
               data_re = 1'b1;
               // A queue holding one entry has its head equal to its tail.
               if (deq_idx == tail_ff[qi]) begin
                  hval_in[qi] = 1'b0;
               end else begin
                  head_in[qi] = link_rdata;
               end
               link_we     = 1'b1;
               link_waddr  = deq_idx;
               link_wdata  = rec_head_ff;
               rec_head_in = deq_idx;
               rec_cnt_in  = rec_cnt_ff + CW'(1);
            end
         end
      end
   end

   // The next item's link word is fetched against the pointers this item leaves.
   assign link_raddr = (nxt_op == OP_ENQ) ? rec_head_in : head_in[QW'(nxt_qid)];

   always_ff @(posedge clock) begin
      if (reset) begin
         hval_ff    <= '0;
         rec_cnt_ff <= '0;
         fresh_ff   <= '0;
      end else begin
         hval_ff    <= hval_in;
         rec_cnt_ff <= rec_cnt_in;
         fresh_ff   <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      rec_head_ff <= rec_head_in;
   end

endmodule

FILE: sv/multi_queue_shared_buffer.sv
// Path: an accepted request beat is held in the input register and then moves to the
// result register, whose contents form the response beat.
// Throughput: one beat per cycle while rsp_stall is low, set by the pointer update loop
// that feeds the link store read address from the pointers the executing beat leaves.
// Reset: synchronous, active high; all queues are empty and every entry is free
// on the cycle after reset, with no clearing pass over the stores.
module multi_queue_shared_buffer
   import mqsb_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int QUEUES  = DEF_QUEUES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int PW = $clog2(ENTRIES);

   // The design is two register stages. The input register holds one request beat
   // together with the link word it needs, which was read from the link store on
   // the cycle the beat was accepted. While the beat sits there the engine works
   // out its status and the new head, tail and free pointers in one pass. When the
   // result register can take it, the beat executes: pointers update, the stores
   // are written and a dequeued word is read straight into the result register.

   logic    a_valid_ff, a_valid_in;
   req_type a_item_ff;
   logic    accept;
   logic    fire;

   logic       r_valid_ff, r_valid_in;
   status_type r_status_ff;
   logic       r_from_mem_ff;

   logic [PW-1:0]     link_raddr, link_waddr, link_wdata, link_rdata;
   logic              link_we;
   logic              data_we, data_re;
   logic [PW-1:0]     data_waddr, data_raddr;
   logic [WORD_W-1:0] data_wdata, data_rdata;
   exec_type          result;

   // The executing beat leaves the input register when the result register is
   // empty or is being emptied in this cycle.
   assign fire       = a_valid_ff && (!r_valid_ff || !rsp_stall);
   assign req_stall  = a_valid_ff && !fire;
   assign accept     = req_valid && !req_stall;
   assign a_valid_in = accept || (a_valid_ff && !fire);
   assign r_valid_in = fire || (r_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_item_ff <= req_payload;
      end
      if (fire) begin
         r_status_ff   <= result.status;
         r_from_mem_ff <= result.from_mem;
      end
   end

   mqsb_engine #(
      .ENTRIES (ENTRIES),
      .QUEUES  (QUEUES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .cur_op     (a_item_ff.opcode),
      .cur_qid    (a_item_ff.queue_id),
      .cur_data   (a_item_ff.data_in),
      .nxt_op     (req_payload.opcode),
      .nxt_qid    (req_payload.queue_id),
      .link_rdata (link_rdata),
      .link_raddr (link_raddr),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .data_we    (data_we),
      .data_waddr (data_waddr),
      .data_wdata (data_wdata),
      .data_re    (data_re),
      .data_raddr (data_raddr),
      .result     (result)
   );

   // Link store: one next pointer per entry, read once per accepted beat.
   mqsb_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (PW)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (accept),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   // Data store: its read register doubles as the data half of the result register.
   mqsb_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (WORD_W)
   ) u_data_ram (
      .clock (clock),
      .we    (data_we),
      .waddr (data_waddr),
      .wdata (data_wdata),
      .re    (data_re),
      .raddr (data_raddr),
      .rdata (data_rdata)
   );

   // Enqueues report a zero word; a failed dequeue reports all ones.
   assign rsp_valid          = r_valid_ff;
   assign rsp_payload.status = r_status_ff;
   assign rsp_payload.data_out = r_from_mem_ff ? data_rdata :
                                 ((r_status_ff == ST_EMPTY) ? EMPTY_WORD : '0);

endmodule

FILE: sv/mqsb_checker.sv
module mqsb_checker
   import mqsb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A held response beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // The request side only backs up behind a stalled response.
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_EMPTY) |-> rsp_payload.data_out == EMPTY_WORD)
      else $error("empty status without all-ones word");

   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_FULL) |-> rsp_payload.data_out == '0)
      else $error("full status without zero word");

   // A request beat taken while the response side is free brings a response beat.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |-> ##[1:2] rsp_valid)
      else $error("no response beat after a request with an idle response side");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_checker (.*);
